[rtl/core/bb_pkg.sv]
// Shared types and constants for the edge-aware 3x3 box blur.
package bb_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int CHAN_W        = 8;
   localparam int PIX_W         = 3 * CHAN_W;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_W      = 16;
   localparam int ROW_W         = HEIGHT_W + 1;
   localparam int CSR_IDX_W     = 8;
   localparam int CSR_DATA_W    = 16;
   localparam int WIDTH_RESET   = 640;
   localparam int HEIGHT_RESET  = 480;
   localparam int SUM_W         = 12;
   localparam int NUM_W         = SUM_W + 1;
   localparam int CNT_W         = 4;
   localparam int DEN_W         = CNT_W + 1;
   localparam int STEP_W        = 3;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   // Per-item control handed from the front to the back
   typedef struct packed {
      logic emit;
      logic use_old;
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic frame_end;
   } bb_ctl_type;

endpackage

[rtl/core/bb_if.sv]
// Channel interfaces: pixel input, blurred result and register write.
interface bb_req_if import bb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [CHAN_W-1:0] in_red;
   logic [CHAN_W-1:0] in_green;
   logic [CHAN_W-1:0] in_blue;
   modport source (output valid, op, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface bb_rsp_if import bb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic              frame_end;
   modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface bb_csr_if import bb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/bb_front.sv]
// Front end: registers, frame position tracking and item classification.
module bb_front import bb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   parameter int WW        = $clog2(MAX_WIDTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   bb_req_if.sink           req,
   bb_csr_if.sink           csr,
   output logic             q_valid,
   input  logic             q_ready,
   output bb_ctl_type       q_ctl,
   output logic [CW-1:0]    q_col,
   output logic [PIX_W-1:0] q_px
);

   localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

   logic [WW-1:0]       width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic                pending_ff;
   logic [CW-1:0]       in_col_ff;
   logic [ROW_W-1:0]    in_row_ff;
   logic [CW-1:0]       out_col_ff;
   logic [HEIGHT_W-1:0] out_row_ff;

   logic [31:0] wv;
   logic        in_frame, drop, accept, col_wrap;
   bb_ctl_type  ctl;

   // Clamp written width to 1..MAX_WIDTH, height zero to one
   always_comb begin
      wv = 32'(csr.data[WIDTH_REG_W-1:0]);
      if (wv == 32'd0) begin
         wv = 32'd1;
      end else if (wv > 32'(MAX_WIDTH)) begin
         wv = 32'(MAX_WIDTH);
      end
      width_in  = wv[WW-1:0];
      height_in = (csr.data[HEIGHT_W-1:0] == '0) ? HEIGHT_W'(1) : csr.data[HEIGHT_W-1:0];
   end

   assign csr.ready = 1'b1;

   // Classify the offered item
   assign in_frame = in_row_ff < ROW_W'(height_ff);
   assign drop     = (op_type'(req.op) == OP_DRAIN) && in_frame;
   assign col_wrap = (32'(in_col_ff) + 32'd1) >= 32'(width_ff);

   always_comb begin
      ctl.use_old   = (in_col_ff == '0);
      ctl.emit      = ctl.use_old ? (in_row_ff >= ROW_W'(2)) : (in_row_ff >= ROW_W'(1));
      ctl.top_ok    = (out_row_ff != '0);
      ctl.bot_ok    = (ROW_W'(out_row_ff) + ROW_W'(1)) < ROW_W'(height_ff);
      ctl.left_ok   = (out_col_ff != '0);
      ctl.right_ok  = !ctl.use_old && ((32'(out_col_ff) + 32'd1) < 32'(width_ff));
      ctl.frame_end = (ROW_W'(out_row_ff) == ROW_W'(height_ff) - ROW_W'(1)) &&
                      (32'(out_col_ff) == 32'(width_ff) - 32'd1);
   end

   assign req.ready = q_ready;
   assign accept    = req.valid && q_ready;
   assign q_valid   = req.valid && !drop;
   assign q_ctl     = ctl;
   assign q_col     = in_col_ff;
   assign q_px      = in_frame ? {req.in_red, req.in_green, req.in_blue} : '0;

   // Advance input and output positions; close the frame on its last result
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WW'(W_RST);
         height_ff  <= HEIGHT_W'(HEIGHT_RESET);
         pending_ff <= 1'b0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         if (csr.valid && !pending_ff) begin
            if (csr.index == REG_IMAGE_WIDTH) begin
               width_ff <= width_in;
            end else if (csr.index == REG_IMAGE_HEIGHT) begin
               height_ff <= height_in;
            end
         end
         if (accept && !drop) begin
            if (ctl.emit && ctl.frame_end) begin
               pending_ff <= 1'b0;
               in_col_ff  <= '0;
               in_row_ff  <= '0;
               out_col_ff <= '0;
               out_row_ff <= '0;
            end else begin
               pending_ff <= 1'b1;
               if (col_wrap) begin
                  in_col_ff <= '0;
                  in_row_ff <= in_row_ff + ROW_W'(1);
               end else begin
                  in_col_ff <= in_col_ff + CW'(1);
               end
               if (ctl.emit) begin
                  if ((32'(out_col_ff) + 32'd1) >= 32'(width_ff)) begin
                     out_col_ff <= '0;
                     out_row_ff <= out_row_ff + HEIGHT_W'(1);
                  end else begin
                     out_col_ff <= out_col_ff + CW'(1);
                  end
               end
            end
         end
      end
   end

endmodule

[rtl/core/bb_queue.sv]
// Two-entry queue between the front and the back.
module bb_queue import bb_pkg::*; #(
   parameter int W = PIX_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic [W-1:0] slot_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Move pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[rtl/core/bb_back.sv]
// Back end: line stores, 3x3 window, masked sums and the rounding divider.
module bb_back import bb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  bb_ctl_type       q_ctl,
   input  logic [CW-1:0]    q_col,
   input  logic [PIX_W-1:0] q_px,
   bb_rsp_if.source         rsp
);

   typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_DIV, S_HOLD} state_type;

   state_type         state_ff;
   logic [PIX_W-1:0]  upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0]  upper_rd_ff, middle_rd_ff, px_ff;
   logic [CW-1:0]     col_ff;
   bb_ctl_type        ctl_ff;
   logic [PIX_W-1:0]  win_ff [3][3];
   logic [PIX_W-1:0]  win_new [3][3];
   logic [NUM_W-1:0]  rem_ff [3];
   logic [CHAN_W-1:0] quo_ff [3];
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff;
   logic              frame_end_ff;
   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] out_ff [3];
   logic              out_end_ff;

   logic [SUM_W-1:0]  sum [3];
   logic [CNT_W-1:0]  cnt;
   logic [2:0]        row_en, col_en;
   logic [PIX_W-1:0]  px_sel;
   logic [NUM_W-1:0]  trial;
   logic              out_free;

   assign q_ready = (state_ff == S_IDLE);

   // Window after this item's column enters
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_new[r][0] = win_ff[r][1];
         win_new[r][1] = win_ff[r][2];
      end
      win_new[0][2] = upper_rd_ff;
      win_new[1][2] = middle_rd_ff;
      win_new[2][2] = px_ff;
   end

   // Sum in-frame neighbors; a column-zero item blurs from the old window
   always_comb begin
      row_en = {ctl_ff.bot_ok, 1'b1, ctl_ff.top_ok};
      col_en[0] = !ctl_ff.use_old && ctl_ff.left_ok;
      col_en[1] = ctl_ff.use_old ? ctl_ff.left_ok : 1'b1;
      col_en[2] = ctl_ff.use_old ? 1'b1 : ctl_ff.right_ok;
      cnt = '0;
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            px_sel = ctl_ff.use_old ? win_ff[r][c] : win_new[r][c];
            if (row_en[r] && col_en[c]) begin
               cnt = cnt + CNT_W'(1);
               for (int ch = 0; ch < 3; ch++) begin
                  sum[ch] = sum[ch] + SUM_W'(px_sel[PIX_W-1-CHAN_W*ch -: CHAN_W]);
               end
            end
         end
      end
   end

   assign trial    = NUM_W'(den_ff) << step_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Line stores: read on pop, write back in the shift cycle
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_valid) begin
         upper_rd_ff  <= upper_mem[q_col];
         middle_rd_ff <= middle_mem[q_col];
      end
      if (state_ff == S_SHIFT) begin
         upper_mem[col_ff]  <= middle_rd_ff;
         middle_mem[col_ff] <= px_ff;
      end
   end

   // Sequencer, window, divider and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  ctl_ff   <= q_ctl;
                  col_ff   <= q_col;
                  px_ff    <= q_px;
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               win_ff <= win_new;
               if (ctl_ff.emit) begin
                  for (int ch = 0; ch < 3; ch++) begin
                     rem_ff[ch] <= NUM_W'({sum[ch], 1'b0}) + NUM_W'(cnt);
                     quo_ff[ch] <= '0;
                  end
                  den_ff       <= {cnt, 1'b0};
                  step_ff      <= STEP_W'(CHAN_W - 1);
                  frame_end_ff <= ctl_ff.frame_end;
                  state_ff     <= S_DIV;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               // One quotient bit per cycle for all three channels
               for (int ch = 0; ch < 3; ch++) begin
                  if (rem_ff[ch] >= trial) begin
                     rem_ff[ch]          <= rem_ff[ch] - trial;
                     quo_ff[ch][step_ff] <= 1'b1;
                  end
               end
               if (step_ff == '0) begin
                  state_ff <= S_HOLD;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            S_HOLD: begin
               if (out_free) begin
                  out_ff       <= quo_ff;
                  out_end_ff   <= frame_end_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_red   = out_ff[0];
   assign rsp.out_green = out_ff[1];
   assign rsp.out_blue  = out_ff[2];
   assign rsp.frame_end = out_end_ff;

endmodule

[rtl/core/box_blur_3x3_edge_aware_top.sv]
// Top level of the edge-aware 3x3 box blur.
//
//   channel   port      direction  payload
//   input     req_chan  sink       op, in_red, in_green, in_blue
//   result    rsp_chan  source     out_red, out_green, out_blue, frame_end
//   register  csr_chan  sink       index, data (0 image_width, 1 image_height)
//
// An item that gives no result occupies the back end for a line store read, then
// window shift and write back; one that gives a result also runs the 8-step shared
// rounding divider and waits for the output register. The front accepts while the
// two-entry queue has room. Reset is synchronous and clears control state only;
// the line stores need no clearing pass. A stalled result holds in the output
// register while the back end goes on with the next item.
module box_blur_3x3_edge_aware_top import bb_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bb_req_if.sink    req_chan,
   bb_rsp_if.source  rsp_chan,
   bb_csr_if.sink    csr_chan
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int QW = $bits(bb_ctl_type) + CW + PIX_W;

   logic             fq_valid, fq_ready, bq_valid, bq_ready;
   bb_ctl_type       fq_ctl, bq_ctl;
   logic [CW-1:0]    fq_col, bq_col;
   logic [PIX_W-1:0] fq_px, bq_px;

   bb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .csr     (csr_chan),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_ctl   (fq_ctl),
      .q_col   (fq_col),
      .q_px    (fq_px)
   );

   bb_queue #(.W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({fq_ctl, fq_col, fq_px}),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  ({bq_ctl, bq_col, bq_px})
   );

   bb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (bq_valid),
      .q_ready (bq_ready),
      .q_ctl   (bq_ctl),
      .q_col   (bq_col),
      .q_px    (bq_px),
      .rsp     (rsp_chan)
   );

endmodule

[rtl/core/bb_checker.sv]
// Port-level checks for the box blur top level, with its bind.
module bb_checker import bb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] out_red,
   input logic [CHAN_W-1:0] out_green,
   input logic [CHAN_W-1:0] out_blue,
   input logic              frame_end
);

   // Reset empties the output register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(out_red) && $stable(out_green) &&
                                  $stable(out_blue) && $stable(frame_end))
      else $error("result changed while stalled");

   // Handshake lines are always driven to known levels
   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_ready, rsp_valid, rsp_ready}))
      else $error("unknown level on a handshake line");

   // An offered result carries a known payload
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({out_red, out_green, out_blue, frame_end}))
      else $error("unknown payload on offered result");

endmodule

bind box_blur_3x3_edge_aware_top bb_checker u_bb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_red   (rsp_chan.out_red),
   .out_green (rsp_chan.out_green),
   .out_blue  (rsp_chan.out_blue),
   .frame_end (rsp_chan.frame_end)
);
